>>> rtl/scf_pkg.sv
package scf_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CFG_W          = COEF_FRAC_BITS + 1;
  localparam int DIFF_W         = SAMPLE_BITS + 1;
  localparam int LP_W           = SAMPLE_BITS + 2;
  localparam int ERR_W          = SAMPLE_BITS + 3;
  localparam int ACC_W          = SAMPLE_BITS + 4;
  localparam int P1_W           = ERR_W + CFG_W + 1;
  localparam int P2_W           = LP_W + CFG_W + 1;
  localparam int IDX_W          = 2;

  localparam logic [IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMOUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_COEF   = 2'd2;

  localparam logic [CFG_W-1:0] FRAC_ONE      = CFG_W'(1) << COEF_FRAC_BITS;
  localparam logic [CFG_W-1:0] AMOUNT_RESET  = CFG_W'(16384);
  localparam logic [CFG_W-1:0] COEF_RESET    = CFG_W'(5738);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_item_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic mul_err;
    logic upd_lp;
    logic load_out;
  } dp_cmd_t;

  function automatic logic [CFG_W-1:0] frac_clamp(input logic [CFG_W-1:0] v);
    frac_clamp = (v > FRAC_ONE) ? FRAC_ONE : v;
  endfunction

  function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] x);
    logic top_same;
    top_same = (x[ACC_W-1:SAMPLE_BITS-1] == '0) || (x[ACC_W-1:SAMPLE_BITS-1] == '1);
    if (top_same) begin
      sat_sample = x[SAMPLE_BITS-1:0];
    end else if (x[ACC_W-1]) begin
      sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/scf_ctrl.sv
module scf_ctrl
  import scf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free));
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.load_in   = accept;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_err = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_lp = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? ST_MUL : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/scf_datapath.sv
module scf_datapath
  import scf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  dp_cmd_t          cmd,
  input  in_item_t         in_data,
  output out_item_t        out_data
);

  logic                     enable_r;
  logic [CFG_W-1:0]         amount_r;
  logic [CFG_W-1:0]         coef_r;
  logic signed [LP_W-1:0]   lp_r;
  logic signed [LP_W-1:0]   lp_nxt;
  sample_t                  left_r;
  sample_t                  right_r;
  logic signed [DIFF_W-1:0] dsum_r;
  logic signed [DIFF_W-1:0] ddiff_r;
  logic signed [P1_W-1:0]   prod1_r;
  logic signed [P1_W-1:0]   prod1_nxt;
  logic signed [P2_W-1:0]   prod2_r;
  logic signed [P2_W-1:0]   prod2_nxt;
  out_item_t                out_r;
  out_item_t                out_nxt;

  logic signed [ERR_W-1:0]   err;
  logic signed [CFG_W:0]     coef_s;
  logic signed [CFG_W:0]     amount_s;
  logic signed [ERR_W-1:0]   lp_inc;
  logic signed [ERR_W-1:0]   lp_sum;
  logic signed [ACC_W-1:0]   side_cut;
  logic signed [ACC_W-1:0]   side_p;
  logic signed [ACC_W-1:0]   mix_l;
  logic signed [ACC_W-1:0]   mix_r;

  assign coef_s   = $signed({1'b0, frac_clamp(coef_r)});
  assign amount_s = $signed({1'b0, frac_clamp(amount_r)});

  assign err       = ERR_W'(ddiff_r) - ERR_W'(lp_r);
  assign prod1_nxt = P1_W'(err) * P1_W'(coef_s);

  assign lp_inc    = prod1_r[COEF_FRAC_BITS +: ERR_W];
  assign lp_sum    = ERR_W'(lp_r) + lp_inc;
  assign lp_nxt    = enable_r ? lp_sum[LP_W-1:0] : '0;
  assign prod2_nxt = P2_W'(lp_nxt) * P2_W'(amount_s);

  assign side_cut = prod2_r[COEF_FRAC_BITS +: ACC_W];
  assign side_p   = ACC_W'(ddiff_r) - side_cut;
  assign mix_l    = ACC_W'(dsum_r) + side_p;
  assign mix_r    = ACC_W'(dsum_r) - side_p;

  always_comb begin
    if (enable_r) begin
      out_nxt.left_out  = sat_sample(mix_l >>> 1);
      out_nxt.right_out = sat_sample(mix_r >>> 1);
    end else begin
      out_nxt.left_out  = left_r;
      out_nxt.right_out = right_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      amount_r <= AMOUNT_RESET;
      coef_r   <= COEF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: enable_r <= cfg_wdata[0];
        REG_AMOUNT: amount_r <= cfg_wdata;
        REG_COEF:   coef_r   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
    end else if (cmd.upd_lp) begin
      lp_r <= lp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      left_r  <= in_data.left_in;
      right_r <= in_data.right_in;
      dsum_r  <= DIFF_W'(in_data.left_in) + DIFF_W'(in_data.right_in);
      ddiff_r <= DIFF_W'(in_data.left_in) - DIFF_W'(in_data.right_in);
    end
    if (cmd.mul_err) begin
      prod1_r <= prod1_nxt;
    end
    if (cmd.upd_lp) begin
      prod2_r <= prod2_nxt;
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/stereo_crossfeed_filter.sv
// Stereo crossfeed: one left/right pair per input beat, one processed pair per output beat.
// Each pair goes through the lowpass error multiply, then the state update with the amount
// multiply, then the mid/side recombination and saturation into the output register. A new pair
// is taken in the cycle its predecessor moves to the output register. With crossfeed disabled
// the pair passes unchanged with the same timing and the lowpass state is cleared.
module stereo_crossfeed_filter
  import scf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  dp_cmd_t cmd;

  scf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  scf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule
